// File: rtl/dcss_pkg.sv
// Shared types and constants for the DHCP client session scheduler.
// Used by dcss_session_store and dcss top level; no dependencies.

package dcss_pkg;

    // item kinds
    localparam logic [1:0] KIND_START = 2'd0;
    localparam logic [1:0] KIND_SCAN  = 2'd1;
    localparam logic [1:0] KIND_FRAME = 2'd2;

    // session phases
    localparam logic [1:0] PH_START    = 2'd0;
    localparam logic [1:0] PH_DISCOVER = 2'd1;
    localparam logic [1:0] PH_REQUEST  = 2'd2;
    localparam logic [1:0] PH_DONE     = 2'd3;

    // result actions
    localparam logic [2:0] ACT_NONE      = 3'd0;
    localparam logic [2:0] ACT_DISCOVER  = 3'd1;
    localparam logic [2:0] ACT_DISC_ERR  = 3'd2;
    localparam logic [2:0] ACT_RETRY     = 3'd3;
    localparam logic [2:0] ACT_REQUEST   = 3'd4;
    localparam logic [2:0] ACT_REQ_ERR   = 3'd5;
    localparam logic [2:0] ACT_ACKED     = 3'd6;

    // register word index (paddr[3:2])
    localparam logic [1:0] REG_SESSION_COUNT = 2'd0;
    localparam logic [1:0] REG_MAX_IN_FLIGHT = 2'd1;
    localparam logic [1:0] REG_WAIT_SECONDS  = 2'd2;

    // frame match and timing constants
    localparam logic [31:0] TIMEOUT_SECONDS = 32'd10;
    localparam logic [7:0]  UDP_PROTOCOL    = 8'd17;
    localparam logic [15:0] XID_MARK        = 16'hfeca;
    localparam logic [23:0] CLIENT_OUI      = 24'hcccccc;
    localparam logic [8:0]  SLOT_LIMIT      = 9'd511;

    // one session entry: stamp holds discover time or request time per phase
    typedef struct packed {
        logic [31:0] lease_ip;
        logic [31:0] stamp;
        logic [1:0]  phase;
    } t_entry;

    typedef struct packed {
        logic rd_en;
        logic wr_en;
        logic clear;
    } t_store_cmd;

endpackage

// File: rtl/dcss_session_store.sv
// Session entry memory with per-entry valid bits for the session scheduler.
// Depends on dcss_pkg (t_entry, t_store_cmd, phase codes).

module dcss_session_store #(
    parameter int DEPTH = 256,
    parameter int AW    = 8
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  dcss_pkg::t_store_cmd i_cmd,
    input  logic [AW-1:0]       i_rd_addr,
    input  logic [AW-1:0]       i_wr_addr,
    input  dcss_pkg::t_entry    i_wr_data,
    output dcss_pkg::t_entry    o_rd_data
);

    dcss_pkg::t_entry r_mem [DEPTH];
    dcss_pkg::t_entry r_rd_data;
    logic             r_rd_valid;
    logic [DEPTH-1:0] r_valid;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // a start item wipes every session back to the start phase at once
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_valid <= '0;
            end else if (i_cmd.wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_cmd.rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    always_comb begin
        o_rd_data = r_rd_data;
        if (!r_rd_valid) begin
            o_rd_data.phase = dcss_pkg::PH_START;
        end
    end

endmodule

// File: rtl/dhcp_client_session_scheduler_unit.sv
// Top level of the DHCP client session scheduler: control, counters, registers.
// Depends on dcss_pkg and dcss_session_store.
//
// Input channel (i_in_valid / o_in_stall) takes one word per item: a start
// item, a scan tick or a received frame summary. Each item yields exactly one
// result word on the output channel (o_out_valid / i_out_stall).
// The accept cycle reads the session entry from the synchronous session
// memory; the execute state then modifies it, writes it back and loads the
// output register. One item is in work at a time, so a new item is taken
// only once the item in work has loaded the output register.
// When the receiver stalls, the result waits in the output register; the
// item in work holds its write-back and result until the output register
// frees, and the input stalls for that whole time.
// Reset sets the registers to session_count 1, max_in_flight 5,
// wait_seconds 1, clears all counters and marks every session as start
// through per-entry valid bits at once; no clearing pass is needed.
// Registers are written over the APB port at byte addresses 0, 4 and 8,
// only while the block is idle, which the user must keep; no logic enforces it.

module dhcp_client_session_scheduler_unit #(
    parameter int MAX_SESSIONS = 256
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // item input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [1:0]  i_kind,
    input  logic [31:0] i_now_seconds,
    input  logic        i_send_ok,
    input  logic        i_dest_is_broadcast,
    input  logic [7:0]  i_ip_protocol,
    input  logic [15:0] i_xid_low,
    input  logic [23:0] i_chaddr_prefix,
    input  logic [7:0]  i_chaddr_index,
    input  logic [31:0] i_offered_ip,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [2:0]  o_action,
    output logic [7:0]  o_session,
    output logic [31:0] o_client_ip,
    output logic [31:0] o_service_seconds,
    output logic        o_all_done,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int AW = (MAX_SESSIONS > 1) ? $clog2(MAX_SESSIONS) : 1;
    localparam logic [8:0] MAX_CNT = 9'(MAX_SESSIONS);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    // configuration registers
    logic [8:0]  r_session_count;
    logic [8:0]  r_max_in_flight;
    logic [15:0] r_wait_seconds;
    logic        cfg_wr;

    // scheduler state
    logic          r_state;
    logic [AW-1:0] r_ptr,     n_ptr;
    logic [31:0]   r_gate,    n_gate;
    logic [8:0]    r_free,    n_free;
    logic [8:0]    r_pending, n_pending;

    // item held during execution
    logic [1:0]    r_kind;
    logic [31:0]   r_now;
    logic          r_send_ok;
    logic [31:0]   r_offered;
    logic          r_go;
    logic [AW-1:0] r_addr;

    // output register
    logic        r_out_valid;
    logic [2:0]  r_action;
    logic [7:0]  r_session;
    logic [31:0] r_client_ip;
    logic [31:0] r_service;
    logic        r_all_done;

    logic [8:0]    count;
    logic          accept;
    logic          done;
    logic          go;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] ptr_wrapped;
    logic [8:0]    ptr_inc;
    logic [31:0]   age;

    dcss_pkg::t_store_cmd st_cmd;
    dcss_pkg::t_entry     rd_entry;
    dcss_pkg::t_entry     wr_entry;

    logic [2:0]  act;
    logic        sess_hit;
    logic [31:0] cip;
    logic [31:0] svc;

    // ---------------- configuration port ----------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_session_count <= 9'd1;
            r_max_in_flight <= 9'd5;
            r_wait_seconds  <= 16'd1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                dcss_pkg::REG_SESSION_COUNT: r_session_count <= pwdata[8:0];
                dcss_pkg::REG_MAX_IN_FLIGHT: r_max_in_flight <= pwdata[8:0];
                dcss_pkg::REG_WAIT_SECONDS:  r_wait_seconds  <= pwdata[15:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            dcss_pkg::REG_SESSION_COUNT: prdata = {23'd0, r_session_count};
            dcss_pkg::REG_MAX_IN_FLIGHT: prdata = {23'd0, r_max_in_flight};
            dcss_pkg::REG_WAIT_SECONDS:  prdata = {16'd0, r_wait_seconds};
            default:                     prdata = 32'd0;
        endcase
    end

    // effective round-robin modulus
    always_comb begin
        if (r_session_count == 9'd0) begin
            count = 9'd1;
        end else if (r_session_count > MAX_CNT) begin
            count = MAX_CNT;
        end else begin
            count = r_session_count;
        end
    end

    // ---------------- accept stage: qualify item, issue read ----------------
    assign o_in_stall = (r_state != ST_IDLE);
    assign accept     = i_in_valid && !o_in_stall;
    assign done       = (r_state == ST_EXEC) && (!r_out_valid || !i_out_stall);

    assign ptr_wrapped = ({{(9-AW){1'b0}}, r_ptr} >= count) ? '0 : r_ptr;

    always_comb begin
        go      = 1'b0;
        rd_addr = ptr_wrapped;
        case (i_kind)
            dcss_pkg::KIND_SCAN: begin
                go = (r_free != 9'd0) && (r_pending != 9'd0) && (i_now_seconds >= r_gate);
            end
            dcss_pkg::KIND_FRAME: begin
                rd_addr = i_chaddr_index[AW-1:0];
                go = i_dest_is_broadcast && (i_ip_protocol == dcss_pkg::UDP_PROTOCOL) &&
                     (i_xid_low == dcss_pkg::XID_MARK) &&
                     (i_chaddr_prefix == dcss_pkg::CLIENT_OUI) &&
                     ({1'b0, i_chaddr_index} < count);
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind    <= i_kind;
            r_now     <= i_now_seconds;
            r_send_ok <= i_send_ok;
            r_offered <= i_offered_ip;
            r_go      <= go;
            r_addr    <= rd_addr;
        end
    end

    // ---------------- execute stage: modify entry and counters ----------------
    assign age     = r_now - rd_entry.stamp;
    assign ptr_inc = {{(9-AW){1'b0}}, r_addr} + 9'd1;

    always_comb begin
        n_ptr     = r_ptr;
        n_gate    = r_gate;
        n_free    = r_free;
        n_pending = r_pending;
        wr_entry  = rd_entry;
        st_cmd    = '0;
        act       = dcss_pkg::ACT_NONE;
        sess_hit  = 1'b0;
        cip       = 32'd0;
        svc       = 32'd0;
        st_cmd.rd_en = accept;
        if (done) begin
            case (r_kind)
                dcss_pkg::KIND_START: begin
                    st_cmd.clear = 1'b1;
                    n_ptr        = '0;
                    n_gate       = 32'd0;
                    n_free       = r_max_in_flight;
                    n_pending    = count;
                end
                dcss_pkg::KIND_SCAN: begin
                    if (r_go) begin
                        n_ptr = (ptr_inc == count) ? '0 : ptr_inc[AW-1:0];
                        case (rd_entry.phase)
                            dcss_pkg::PH_START: begin
                                sess_hit     = 1'b1;
                                st_cmd.wr_en = 1'b1;
                                if (r_send_ok) begin
                                    wr_entry.stamp = r_now;
                                    wr_entry.phase = dcss_pkg::PH_DISCOVER;
                                    n_free         = r_free - 9'd1;
                                    n_gate         = r_now + {16'd0, r_wait_seconds};
                                    act            = dcss_pkg::ACT_DISCOVER;
                                end else begin
                                    wr_entry.phase = dcss_pkg::PH_DONE;
                                    if (r_pending != 9'd0) n_pending = r_pending - 9'd1;
                                    act            = dcss_pkg::ACT_DISC_ERR;
                                end
                            end
                            dcss_pkg::PH_DISCOVER, dcss_pkg::PH_REQUEST: begin
                                if (age > dcss_pkg::TIMEOUT_SECONDS) begin
                                    st_cmd.wr_en   = 1'b1;
                                    wr_entry.phase = dcss_pkg::PH_START;
                                    if (r_free < dcss_pkg::SLOT_LIMIT) n_free = r_free + 9'd1;
                                    n_gate   = r_now + 32'd1;
                                    act      = dcss_pkg::ACT_RETRY;
                                    sess_hit = 1'b1;
                                    svc      = age;
                                    n_ptr    = r_addr;  // revisit the same session
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                dcss_pkg::KIND_FRAME: begin
                    if (r_go) begin
                        case (rd_entry.phase)
                            dcss_pkg::PH_DISCOVER: begin
                                sess_hit     = 1'b1;
                                st_cmd.wr_en = 1'b1;
                                if (r_send_ok) begin
                                    wr_entry.stamp    = r_now;
                                    wr_entry.lease_ip = r_offered;
                                    wr_entry.phase    = dcss_pkg::PH_REQUEST;
                                    act               = dcss_pkg::ACT_REQUEST;
                                    cip               = r_offered;
                                    svc               = age;
                                end else begin
                                    wr_entry.phase = dcss_pkg::PH_DONE;
                                    if (r_pending != 9'd0) n_pending = r_pending - 9'd1;
                                    if (r_free < dcss_pkg::SLOT_LIMIT) n_free = r_free + 9'd1;
                                    act            = dcss_pkg::ACT_REQ_ERR;
                                end
                            end
                            dcss_pkg::PH_REQUEST: begin
                                sess_hit       = 1'b1;
                                st_cmd.wr_en   = 1'b1;
                                wr_entry.phase = dcss_pkg::PH_DONE;
                                if (r_pending != 9'd0) n_pending = r_pending - 9'd1;
                                if (r_free < dcss_pkg::SLOT_LIMIT) n_free = r_free + 9'd1;
                                act = dcss_pkg::ACT_ACKED;
                                cip = rd_entry.lease_ip;
                                svc = age;
                            end
                            default: ;
                        endcase
                    end
                end
                default: ;
            endcase
        end
    end

    dcss_session_store #(
        .DEPTH (MAX_SESSIONS),
        .AW    (AW)
    ) u_store (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (st_cmd),
        .i_rd_addr (rd_addr),
        .i_wr_addr (r_addr),
        .i_wr_data (wr_entry),
        .o_rd_data (rd_entry)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_IDLE;
            r_ptr     <= '0;
            r_gate    <= 32'd0;
            r_free    <= 9'd0;
            r_pending <= 9'd0;
        end else begin
            r_ptr     <= n_ptr;
            r_gate    <= n_gate;
            r_free    <= n_free;
            r_pending <= n_pending;
            if (accept) begin
                r_state <= ST_EXEC;
            end else if (done) begin
                r_state <= ST_IDLE;
            end
        end
    end

    // ---------------- output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (done) begin
            r_action    <= act;
            r_session   <= sess_hit ? 8'(r_addr) : 8'd0;
            r_client_ip <= cip;
            r_service   <= svc;
            r_all_done  <= (n_pending == 9'd0);
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_action          = r_action;
    assign o_session         = r_session;
    assign o_client_ip       = r_client_ip;
    assign o_service_seconds = r_service;
    assign o_all_done        = r_all_done;

    // ---------------- assertions ----------------
    a_done_loads_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        done |=> o_out_valid)
        else $error("finished item did not load the output register");

    a_pending_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending <= MAX_CNT)
        else $error("pending session count above session limit");

    a_write_in_exec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (st_cmd.wr_en || st_cmd.clear) |-> (r_state == ST_EXEC) && !st_cmd.rd_en)
        else $error("session store written outside execute stage");

    a_none_is_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_action == dcss_pkg::ACT_NONE) |->
            (o_session == 8'd0) && (o_client_ip == 32'd0) && (o_service_seconds == 32'd0))
        else $error("empty result word carries session data");

endmodule

// File: tb/testbench.sv
// Self-checking testbench for dhcp_client_session_scheduler_unit.
// Depends on dcss_pkg and the RTL. A directed table runs first, then random
// phases over register settings; words with no table value use a session predictor.

module testbench;

    localparam int          SESSION_DEPTH = 256;
    localparam int          STUCK_LIMIT   = 2000;
    localparam int          PHASE_ITEMS   = 64;
    localparam logic [1:0]  KIND_UNUSED   = 2'd3;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] now;
        logic        send_ok;
        logic        bcast;
        logic [7:0]  proto;
        logic [15:0] xid;
        logic [23:0] prefix;
        logic [7:0]  idx;
        logic [31:0] offered;
    } t_item;

    typedef struct packed {
        logic [2:0]  action;
        logic [7:0]  session;
        logic [31:0] client_ip;
        logic [31:0] service_seconds;
        logic        all_done;
    } t_result;

    typedef struct {
        t_item   it;
        bit      typed;
        t_result want;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        o_in_stall;
    logic [1:0]  i_kind = '0;
    logic [31:0] i_now_seconds = '0;
    logic        i_send_ok = 1'b0;
    logic        i_dest_is_broadcast = 1'b0;
    logic [7:0]  i_ip_protocol = '0;
    logic [15:0] i_xid_low = '0;
    logic [23:0] i_chaddr_prefix = '0;
    logic [7:0]  i_chaddr_index = '0;
    logic [31:0] i_offered_ip = '0;
    logic        o_out_valid;
    logic        i_out_stall = 1'b0;
    logic [2:0]  o_action;
    logic [7:0]  o_session;
    logic [31:0] o_client_ip;
    logic [31:0] o_service_seconds;
    logic        o_all_done;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [3:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    dhcp_client_session_scheduler_unit #(
        .MAX_SESSIONS(SESSION_DEPTH)
    ) u_dut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_in_valid          (i_in_valid),
        .o_in_stall          (o_in_stall),
        .i_kind              (i_kind),
        .i_now_seconds       (i_now_seconds),
        .i_send_ok           (i_send_ok),
        .i_dest_is_broadcast (i_dest_is_broadcast),
        .i_ip_protocol       (i_ip_protocol),
        .i_xid_low           (i_xid_low),
        .i_chaddr_prefix     (i_chaddr_prefix),
        .i_chaddr_index      (i_chaddr_index),
        .i_offered_ip        (i_offered_ip),
        .o_out_valid         (o_out_valid),
        .i_out_stall         (i_out_stall),
        .o_action            (o_action),
        .o_session           (o_session),
        .o_client_ip         (o_client_ip),
        .o_service_seconds   (o_service_seconds),
        .o_all_done          (o_all_done),
        .psel                (psel),
        .penable             (penable),
        .pwrite              (pwrite),
        .paddr               (paddr),
        .pwdata              (pwdata),
        .prdata              (prdata),
        .pready              (pready)
    );

    // predictor state
    logic [8:0]  cfg_session_count = 9'd1;
    logic [8:0]  cfg_max_in_flight = 9'd5;
    logic [15:0] cfg_wait = 16'd1;
    logic [1:0]  m_phase [SESSION_DEPTH];
    logic [31:0] disc_stamp [SESSION_DEPTH];
    logic [31:0] req_stamp [SESSION_DEPTH];
    logic [31:0] lease_addr [SESSION_DEPTH];
    int          scan_ptr = 0;
    logic [31:0] gate = '0;
    int          free_slots = 0;
    int          pending = 0;

    t_result     pending_results [$];
    t_row        directed_rows [$];
    int          mismatches = 0;
    int          stuck_cycles = 0;
    int          burst_left = 0;
    logic [31:0] sim_now = '0;

    int plan_count [7] = '{4, 0, 256, 16, 8, 2, 511};
    int plan_max   [7] = '{5, 2, 256, 0, 3, 3, 511};
    int plan_wait  [7] = '{1, 0, 0, 3, 2, 1, 65535};
    bit plan_start [7] = '{1, 1, 1, 1, 1, 0, 1};

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        for (int i = 0; i < SESSION_DEPTH; i++) begin
            m_phase[i] = dcss_pkg::PH_START;
        end
    end

    function automatic int live_count();
        if (cfg_session_count == 0) return 1;
        if (cfg_session_count > SESSION_DEPTH) return SESSION_DEPTH;
        return int'(cfg_session_count);
    endfunction

    function automatic void release_slot();
        if (free_slots < dcss_pkg::SLOT_LIMIT) free_slots++;
    endfunction

    function automatic void retire_session();
        if (pending != 0) pending--;
    endfunction

    // advance the session table by one item and return the word it yields
    function automatic t_result session_step(input t_item it);
        t_result     r;
        int          count;
        int          p;
        logic [1:0]  ph;
        logic [31:0] age;
        bit          advance;
        r = '0;
        count = live_count();
        case (it.kind)
            dcss_pkg::KIND_START: begin
                for (int i = 0; i < SESSION_DEPTH; i++) m_phase[i] = dcss_pkg::PH_START;
                scan_ptr = 0;
                gate = '0;
                free_slots = int'(cfg_max_in_flight);
                pending = count;
            end
            dcss_pkg::KIND_SCAN: begin
                if (free_slots != 0 && pending != 0 && it.now >= gate) begin
                    if (scan_ptr >= count) scan_ptr = 0;
                    p = scan_ptr;
                    ph = m_phase[p];
                    advance = 1'b1;
                    if (ph == dcss_pkg::PH_START) begin
                        r.session = 8'(p);
                        if (it.send_ok) begin
                            disc_stamp[p] = it.now;
                            m_phase[p] = dcss_pkg::PH_DISCOVER;
                            free_slots--;
                            gate = it.now + 32'(cfg_wait);
                            r.action = dcss_pkg::ACT_DISCOVER;
                        end else begin
                            m_phase[p] = dcss_pkg::PH_DONE;
                            retire_session();
                            r.action = dcss_pkg::ACT_DISC_ERR;
                        end
                    end else if (ph != dcss_pkg::PH_DONE) begin
                        age = it.now - ((ph == dcss_pkg::PH_DISCOVER) ? disc_stamp[p] :
                                                                       req_stamp[p]);
                        if (age > dcss_pkg::TIMEOUT_SECONDS) begin
                            m_phase[p] = dcss_pkg::PH_START;
                            release_slot();
                            gate = it.now + 32'd1;
                            r.action = dcss_pkg::ACT_RETRY;
                            r.session = 8'(p);
                            r.service_seconds = age;
                            advance = 1'b0;
                        end
                    end
                    if (advance) scan_ptr = (p + 1) % count;
                end
            end
            dcss_pkg::KIND_FRAME: begin
                if (it.bcast && it.proto == dcss_pkg::UDP_PROTOCOL &&
                    it.xid == dcss_pkg::XID_MARK &&
                    it.prefix == dcss_pkg::CLIENT_OUI && int'(it.idx) < count) begin
                    p = int'(it.idx);
                    if (m_phase[p] == dcss_pkg::PH_DISCOVER) begin
                        r.session = it.idx;
                        if (it.send_ok) begin
                            req_stamp[p] = it.now;
                            lease_addr[p] = it.offered;
                            m_phase[p] = dcss_pkg::PH_REQUEST;
                            r.action = dcss_pkg::ACT_REQUEST;
                            r.client_ip = it.offered;
                            r.service_seconds = it.now - disc_stamp[p];
                        end else begin
                            m_phase[p] = dcss_pkg::PH_DONE;
                            retire_session();
                            release_slot();
                            r.action = dcss_pkg::ACT_REQ_ERR;
                        end
                    end else if (m_phase[p] == dcss_pkg::PH_REQUEST) begin
                        m_phase[p] = dcss_pkg::PH_DONE;
                        retire_session();
                        release_slot();
                        r.action = dcss_pkg::ACT_ACKED;
                        r.session = it.idx;
                        r.client_ip = lease_addr[p];
                        r.service_seconds = it.now - req_stamp[p];
                    end
                end
            end
            default: ;
        endcase
        r.all_done = (pending == 0);
        return r;
    endfunction

    // non-frame item; frame fields are don't-care and get random values
    function automatic t_item tick(input logic [1:0] kind, input logic [31:0] now,
                                   input logic ok);
        t_item it;
        it.kind = kind;
        it.now = now;
        it.send_ok = ok;
        it.bcast = 1'($urandom);
        it.proto = 8'($urandom);
        it.xid = 16'($urandom);
        it.prefix = 24'($urandom);
        it.idx = 8'($urandom);
        it.offered = $urandom;
        return it;
    endfunction

    function automatic t_item frame(input logic [31:0] now, input logic ok,
                                    input logic bcast, input logic [7:0] proto,
                                    input logic [15:0] xid, input logic [23:0] prefix,
                                    input logic [7:0] idx, input logic [31:0] offered);
        t_item it;
        it = '{dcss_pkg::KIND_FRAME, now, ok, bcast, proto, xid, prefix, idx, offered};
        return it;
    endfunction

    // frame summary that passes every match field
    function automatic t_item hit_frame(input logic [31:0] now, input logic ok,
                                        input logic [7:0] idx, input logic [31:0] offered);
        return frame(now, ok, 1'b1, dcss_pkg::UDP_PROTOCOL, dcss_pkg::XID_MARK,
                     dcss_pkg::CLIENT_OUI, idx, offered);
    endfunction

    function automatic t_result word(input logic [2:0] act, input logic [7:0] sess,
                                     input logic [31:0] cip, input logic [31:0] svc,
                                     input logic done);
        t_result r;
        r = '{act, sess, cip, svc, done};
        return r;
    endfunction

    function automatic void add_row(input t_item it, input bit typed, input t_result want);
        t_row row;
        row.it = it;
        row.typed = typed;
        row.want = want;
        directed_rows.push_back(row);
    endfunction

    // random item, mostly well-formed traffic for sessions already in flight
    function automatic t_item make_item();
        t_item it;
        int    roll;
        int    count;
        int    live [$];
        roll = $urandom_range(0, 99);
        if (roll < 2) sim_now = $urandom;
        else if (roll < 7) sim_now += $urandom_range(0, 200000);
        else sim_now += $urandom_range(0, 4);
        roll = $urandom_range(0, 99);
        if (roll < 4) return tick(dcss_pkg::KIND_START, sim_now, 1'($urandom));
        if (roll < 6) return tick(KIND_UNUSED, sim_now, 1'($urandom));
        if (roll < 54) return tick(dcss_pkg::KIND_SCAN, sim_now, $urandom_range(0, 9) != 0);
        count = live_count();
        for (int i = 0; i < count; i++) begin
            if (m_phase[i] == dcss_pkg::PH_DISCOVER || m_phase[i] == dcss_pkg::PH_REQUEST)
                live.push_back(i);
        end
        it = hit_frame(sim_now, $urandom_range(0, 9) != 0,
                       8'(count > 255 ? 255 : $urandom_range(0, count)), $urandom);
        if (live.size() != 0 && $urandom_range(0, 3) != 0)
            it.idx = 8'(live[$urandom_range(0, live.size() - 1)]);
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 4))
                0: it.bcast = 1'b0;
                1: it.proto = 8'($urandom);
                2: it.xid = 16'($urandom);
                3: it.prefix = 24'($urandom);
                default: it.idx = 8'($urandom);
            endcase
        end
        return it;
    endfunction

    task automatic flag_mismatch(input string msg);
        mismatches++;
        if (mismatches <= 10) $display("%s", msg);
    endtask

    // offer one word, with bursts and random gaps between them
    task automatic send_word(input t_item it, input bit typed, input t_result want);
        t_result predicted;
        int      gap;
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                i_in_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        i_kind <= it.kind;
        i_now_seconds <= it.now;
        i_send_ok <= it.send_ok;
        i_dest_is_broadcast <= it.bcast;
        i_ip_protocol <= it.proto;
        i_xid_low <= it.xid;
        i_chaddr_prefix <= it.prefix;
        i_chaddr_index <= it.idx;
        i_offered_ip <= it.offered;
        i_in_valid <= 1'b1;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        predicted = session_step(it);
        pending_results.push_back(typed ? want : predicted);
    endtask

    task automatic drain();
        i_in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // APB write, then read back the same register
    task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        if (prdata !== value)
            flag_mismatch($sformatf("readback reg %0d: want %h got %h", idx, value, prdata));
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
        case (idx)
            dcss_pkg::REG_SESSION_COUNT: cfg_session_count = value[8:0];
            dcss_pkg::REG_MAX_IN_FLIGHT: cfg_max_in_flight = value[8:0];
            dcss_pkg::REG_WAIT_SECONDS:  cfg_wait = value[15:0];
            default: ;
        endcase
    endtask

    // result checker and watchdog
    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                if (pending_results.size() == 0) begin
                    flag_mismatch($sformatf("unexpected word: act %0d sess %0d", o_action,
                                            o_session));
                end else begin
                    want = pending_results.pop_front();
                    if (want.action !== o_action || want.session !== o_session ||
                        want.client_ip !== o_client_ip ||
                        want.service_seconds !== o_service_seconds ||
                        want.all_done !== o_all_done)
                        flag_mismatch($sformatf(
                            "word mismatch: want %0d/%0d/%h/%h/%0d got %0d/%0d/%h/%h/%0d",
                            want.action, want.session, want.client_ip, want.service_seconds,
                            want.all_done, o_action, o_session, o_client_ip,
                            o_service_seconds, o_all_done));
                end
            end
            if ((o_out_valid && !i_out_stall) || (i_in_valid && !o_in_stall) || psel)
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= STUCK_LIMIT) begin
                $display("status: fail");
                $finish;
            end
        end
    end

    // receiver: stall pattern in segments, with a long hold-off now and then
    initial begin : out_side
        int seg;
        int len;
        int mode;
        int c;
        seg = 0;
        forever begin
            mode = (seg % 9 == 2) ? 3 : $urandom_range(0, 2);
            len = (mode == 3) ? 60 : $urandom_range(10, 60);
            for (c = 0; c < len; c++) begin
                case (mode)
                    0: i_out_stall <= 1'b0;
                    1: i_out_stall <= ($urandom_range(0, 9) < 3);
                    2: i_out_stall <= ($urandom_range(0, 9) < 7);
                    default: i_out_stall <= 1'b1;
                endcase
                @(posedge i_clk);
            end
            seg++;
        end
    end

    initial begin : stimulus
        int   n;
        int   ph;
        t_row row;

        // reset registers: one session, five in flight, one second gate
        add_row(tick(dcss_pkg::KIND_SCAN, 32'd0, 1'b1), 1,
                word(dcss_pkg::ACT_NONE, 0, 0, 0, 1));
        add_row(tick(KIND_UNUSED, 32'd0, 1'b1), 1, word(dcss_pkg::ACT_NONE, 0, 0, 0, 1));
        add_row(tick(dcss_pkg::KIND_START, 32'd0, 1'b1), 1,
                word(dcss_pkg::ACT_NONE, 0, 0, 0, 0));
        add_row(hit_frame(32'd1, 1'b1, 8'd0, 32'd7), 1, word(dcss_pkg::ACT_NONE, 0, 0, 0, 0));
        add_row(tick(dcss_pkg::KIND_SCAN, 32'd100, 1'b1), 1,
                word(dcss_pkg::ACT_DISCOVER, 0, 0, 0, 0));
        // one bad field at a time: no match
        add_row(frame(32'd101, 1'b1, 1'b0, dcss_pkg::UDP_PROTOCOL, dcss_pkg::XID_MARK,
                      dcss_pkg::CLIENT_OUI, 8'd0, 32'd7),
                1, word(dcss_pkg::ACT_NONE, 0, 0, 0, 0));
        add_row(frame(32'd101, 1'b1, 1'b1, 8'hff, dcss_pkg::XID_MARK,
                      dcss_pkg::CLIENT_OUI, 8'd0, 32'd7),
                1, word(dcss_pkg::ACT_NONE, 0, 0, 0, 0));
        add_row(frame(32'd101, 1'b1, 1'b1, dcss_pkg::UDP_PROTOCOL, 16'h0000,
                      dcss_pkg::CLIENT_OUI, 8'd0, 32'd7),
                1, word(dcss_pkg::ACT_NONE, 0, 0, 0, 0));
        add_row(frame(32'd101, 1'b1, 1'b1, dcss_pkg::UDP_PROTOCOL, dcss_pkg::XID_MARK,
                      24'hffffff, 8'd0, 32'd7),
                1, word(dcss_pkg::ACT_NONE, 0, 0, 0, 0));
        add_row(hit_frame(32'd101, 1'b1, 8'd1, 32'd7), 1,
                word(dcss_pkg::ACT_NONE, 0, 0, 0, 0));
        add_row(hit_frame(32'd103, 1'b1, 8'd0, 32'hffffffff), 1,
                word(dcss_pkg::ACT_REQUEST, 0, 32'hffffffff, 32'd3, 0));
        // timeout only when strictly older than ten seconds
        add_row(tick(dcss_pkg::KIND_SCAN, 32'd113, 1'b1), 1,
                word(dcss_pkg::ACT_NONE, 0, 0, 0, 0));
        add_row(tick(dcss_pkg::KIND_SCAN, 32'd114, 1'b1), 1,
                word(dcss_pkg::ACT_RETRY, 0, 0, 32'd11, 0));
        add_row(tick(dcss_pkg::KIND_SCAN, 32'd114, 1'b1), 1,
                word(dcss_pkg::ACT_NONE, 0, 0, 0, 0));
        add_row(tick(dcss_pkg::KIND_SCAN, 32'd115, 1'b0), 1,
                word(dcss_pkg::ACT_DISC_ERR, 0, 0, 0, 1));
        // time wraps past 2^32
        add_row(tick(dcss_pkg::KIND_START, 32'hffffffff, 1'b1), 1,
                word(dcss_pkg::ACT_NONE, 0, 0, 0, 0));
        add_row(tick(dcss_pkg::KIND_SCAN, 32'hfffffffa, 1'b1), 1,
                word(dcss_pkg::ACT_DISCOVER, 0, 0, 0, 0));
        add_row(hit_frame(32'd2, 1'b1, 8'd0, 32'd0), 1,
                word(dcss_pkg::ACT_REQUEST, 0, 0, 32'd8, 0));
        add_row(hit_frame(32'd5, 1'b0, 8'd0, 32'd9), 1,
                word(dcss_pkg::ACT_ACKED, 0, 0, 32'd3, 1));
        // offer without transmit slot ends the session
        add_row(tick(dcss_pkg::KIND_START, 32'd0, 1'b1), 1,
                word(dcss_pkg::ACT_NONE, 0, 0, 0, 0));
        add_row(tick(dcss_pkg::KIND_SCAN, 32'd50, 1'b1), 0, '0);
        add_row(hit_frame(32'd52, 1'b0, 8'd0, 32'd1), 1,
                word(dcss_pkg::ACT_REQ_ERR, 0, 0, 0, 1));
        add_row(hit_frame(32'd53, 1'b1, 8'd0, 32'd1), 1,
                word(dcss_pkg::ACT_NONE, 0, 0, 0, 1));
        add_row(tick(dcss_pkg::KIND_SCAN, 32'd60, 1'b1), 1,
                word(dcss_pkg::ACT_NONE, 0, 0, 0, 1));

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (n = 0; n < directed_rows.size(); n++) begin
            row = directed_rows[n];
            send_word(row.it, row.typed, row.want);
        end

        for (ph = 0; ph < 7; ph++) begin
            drain();
            apb_write(dcss_pkg::REG_SESSION_COUNT, 32'(plan_count[ph]));
            apb_write(dcss_pkg::REG_MAX_IN_FLIGHT, 32'(plan_max[ph]));
            apb_write(dcss_pkg::REG_WAIT_SECONDS, 32'(plan_wait[ph]));
            // one phase keeps the old run so the pointer may sit past a smaller count
            if (plan_start[ph]) send_word(tick(dcss_pkg::KIND_START, sim_now, 1'b1), 0, '0);
            for (n = 0; n < PHASE_ITEMS; n++) send_word(make_item(), 0, '0);
        end

        drain();
        repeat (10) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: dhcp_client_session_scheduler_unit.f
rtl/dcss_pkg.sv
rtl/dcss_session_store.sv
rtl/dhcp_client_session_scheduler_unit.sv
tb/testbench.sv
